/* rtl/segment_lcd_number_formatter_macros.svh */
// Assertion macros for the segment LCD number formatter.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef SEGMENT_LCD_NUMBER_FORMATTER_MACROS_SVH
`define SEGMENT_LCD_NUMBER_FORMATTER_MACROS_SVH

// same-cycle implication
`define SLNF_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLNF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/slnf_pkg.sv */
// Shared types and constants for the segment LCD number formatter.
// No dependencies.
`default_nettype none

package slnf_pkg;

    typedef enum logic [1:0] {
        CMD_NUMBER = 2'd0,
        CMD_VALUES = 2'd1,
        CMD_TIME   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic vld;
        t_cmd cmd;
        logic active;
        logic neg1;
        logic neg2;
    } t_ctl;

    localparam int BIN_W      = 32;
    localparam int DIGITS     = 10;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int DAB_STAGES = 4;
    localparam int DAB_STEPS  = BIN_W / DAB_STAGES;
    localparam int MAG_W      = 14;
    localparam int LINE_W     = 40;

    localparam logic [2:0] LINE_BYTES = 3'd5;

    localparam logic [3:0] CH_SPACE = 4'd0;
    localparam logic [3:0] CH_ZERO  = 4'd10;
    localparam logic [3:0] CH_MINUS = 4'd15;
    localparam logic [3:0] DIG_NINE = 4'd9;

    localparam logic signed [15:0] VAL_HI = 16'sd9999;
    localparam logic signed [15:0] VAL_LO = -16'sd999;
    localparam logic [13:0] VAL_SCALE     = 14'd10000;

    // m/6 = hi*10922 + (4*hi + lo)/6, the second term by reciprocal
    localparam logic [13:0] DIV6_HI     = 14'd10922;
    localparam logic [18:0] DIV6_RECIP  = 19'd349526;
    localparam int          DIV6_SHIFT  = 21;

    localparam logic REG_BLANK_IDX = 1'b0;

endpackage

`default_nettype wire

/* rtl/slnf_prep.sv */
// Front stages: clamp, divide minutes by six, merge two values into one word.
// Depends on slnf_pkg.
`default_nettype none

module slnf_prep (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  slnf_pkg::t_ctl      i_ctl,
    input  logic [31:0]         i_number,
    input  logic signed [15:0]  i_first_value,
    input  logic signed [15:0]  i_second_value,
    input  logic [31:0]         i_minutes,
    output slnf_pkg::t_ctl      o_ctl,
    output logic [31:0]         o_value
);
    import slnf_pkg::*;

    function automatic logic [MAG_W:0] clamp_mag(input logic signed [15:0] v);
        logic signed [15:0] c;
        logic signed [15:0] n;
        c = v;
        if (v > VAL_HI) begin
            c = VAL_HI;
        end else if (v < VAL_LO) begin
            c = VAL_LO;
        end
        n = -c;
        if (c < 0) begin
            return {1'b1, n[MAG_W-1:0]};
        end
        return {1'b0, c[MAG_W-1:0]};
    endfunction

    // stage 1
    t_ctl              r_s1_ctl;
    logic [31:0]       r_s1_num;
    logic [15:0]       r_s1_hi;
    logic [18:0]       r_s1_t;
    logic [MAG_W-1:0]  r_s1_mag1;
    logic [MAG_W-1:0]  r_s1_mag2;
    logic [MAG_W:0]    n_c1;
    logic [MAG_W:0]    n_c2;
    t_ctl              n_ctl1;
    logic [18:0]       n_t;

    always_comb begin
        n_c1   = clamp_mag(i_first_value);
        n_c2   = clamp_mag(i_second_value);
        n_ctl1 = i_ctl;
        n_ctl1.neg1 = n_c1[MAG_W];
        n_ctl1.neg2 = n_c2[MAG_W];
        n_t    = {1'b0, i_minutes[31:16], 2'b00} + {3'd0, i_minutes[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= n_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_num  <= i_number;
            r_s1_hi   <= i_minutes[31:16];
            r_s1_t    <= n_t;
            r_s1_mag1 <= n_c1[MAG_W-1:0];
            r_s1_mag2 <= n_c2[MAG_W-1:0];
        end
    end

    // stage 2: products
    t_ctl              r_s2_ctl;
    logic [31:0]       r_s2_num;
    logic [29:0]       r_s2_p1;
    logic [15:0]       r_s2_q;
    logic [27:0]       r_s2_m1;
    logic [MAG_W-1:0]  r_s2_mag2;
    logic [29:0]       prod1;
    logic [37:0]       prod2;
    logic [27:0]       prod3;

    assign prod1 = {14'd0, r_s1_hi} * {16'd0, DIV6_HI};
    assign prod2 = {19'd0, r_s1_t} * {19'd0, DIV6_RECIP};
    assign prod3 = {14'd0, r_s1_mag1} * {14'd0, VAL_SCALE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (i_en) begin
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_num  <= r_s1_num;
            r_s2_p1   <= prod1;
            r_s2_q    <= prod2[DIV6_SHIFT +: 16];
            r_s2_m1   <= prod3;
            r_s2_mag2 <= r_s1_mag2;
        end
    end

    // stage 3: select the word to convert
    t_ctl        r_s3_ctl;
    logic [31:0] r_s3_value;
    logic [31:0] n_value;

    always_comb begin
        case (r_s2_ctl.cmd)
            CMD_NUMBER: n_value = r_s2_num;
            CMD_VALUES: n_value = {4'd0, r_s2_m1} + {18'd0, r_s2_mag2};
            CMD_TIME:   n_value = {2'd0, r_s2_p1} + {16'd0, r_s2_q};
            CMD_CLEAR:  n_value = '0;
            default:    n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
        end else if (i_en) begin
            r_s3_ctl <= r_s2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_value <= n_value;
        end
    end

    assign o_ctl   = r_s3_ctl;
    assign o_value = r_s3_value;

endmodule

`default_nettype wire

/* rtl/slnf_dabble.sv */
// One stage of the binary to BCD pipeline: shift-add-3 over a slice of bits.
// Depends on slnf_pkg.
`default_nettype none

module slnf_dabble (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  slnf_pkg::t_ctl              i_ctl,
    input  logic [slnf_pkg::BCD_W-1:0]  i_bcd,
    input  logic [slnf_pkg::BIN_W-1:0]  i_bin,
    output slnf_pkg::t_ctl              o_ctl,
    output logic [slnf_pkg::BCD_W-1:0]  o_bcd,
    output logic [slnf_pkg::BIN_W-1:0]  o_bin
);
    import slnf_pkg::*;

    t_ctl                    r_ctl;
    logic [BCD_W-1:0]        r_bcd;
    logic [BIN_W-1:0]        r_bin;
    logic [BCD_W+BIN_W-1:0]  n_acc;

    always_comb begin
        n_acc = {i_bcd, i_bin};
        for (int s = 0; s < DAB_STEPS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (n_acc[BIN_W + 4*d +: 4] >= 4'd5) begin
                    n_acc[BIN_W + 4*d +: 4] = n_acc[BIN_W + 4*d +: 4] + 4'd3;
                end
            end
            n_acc = {n_acc[BCD_W+BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bcd <= n_acc[BIN_W +: BCD_W];
            r_bin <= n_acc[BIN_W-1:0];
        end
    end

    assign o_ctl = r_ctl;
    assign o_bcd = r_bcd;
    assign o_bin = r_bin;

endmodule

`default_nettype wire

/* rtl/slnf_serial.sv */
// Line formatter and five-beat byte serializer; sets the pipeline advance.
// Depends on slnf_pkg.
`default_nettype none

module slnf_serial (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  slnf_pkg::t_ctl              i_ctl,
    input  logic [slnf_pkg::BCD_W-1:0]  i_bcd,
    input  logic [7:0]                  i_blank,
    input  logic                        i_tready,
    output logic                        o_tvalid,
    output logic [7:0]                  o_tdata,
    output logic                        o_tlast,
    output logic                        o_en
);
    import slnf_pkg::*;

    function automatic logic [3:0] code(input logic [3:0] d);
        return (d == 4'd0) ? CH_ZERO : d;
    endfunction

    logic [3:0]         dg [DIGITS];
    logic [3:0]         ch [DIGITS];
    logic [3:0]         hrs [3];
    logic               sat;
    logic [LINE_W-1:0]  n_line;
    logic [LINE_W-1:0]  r_line;
    logic [2:0]         r_cnt;
    logic               can_load;
    logic               load;
    logic               beat;

    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            dg[d] = i_bcd[4*d +: 4];
        end
        sat = (i_bcd[BCD_W-1:16] != '0);
        hrs[0] = sat ? DIG_NINE : dg[1];
        hrs[1] = sat ? DIG_NINE : dg[2];
        hrs[2] = sat ? DIG_NINE : dg[3];
        for (int i = 0; i < DIGITS; i++) begin
            ch[i] = CH_SPACE;
        end
        case (i_ctl.cmd)
            CMD_NUMBER: begin
                for (int i = 0; i < DIGITS; i++) begin
                    ch[i] = code(dg[DIGITS-1-i]);
                end
            end
            CMD_VALUES: begin
                ch[0] = i_ctl.neg1 ? CH_MINUS : code(dg[7]);
                ch[1] = code(dg[6]);
                ch[2] = code(dg[5]);
                ch[3] = code(dg[4]);
                ch[6] = i_ctl.neg2 ? CH_MINUS : code(dg[3]);
                ch[7] = code(dg[2]);
                ch[8] = code(dg[1]);
                ch[9] = code(dg[0]);
            end
            CMD_TIME: begin
                ch[0] = i_ctl.active ? CH_MINUS : CH_SPACE;
                ch[2] = CH_ZERO;
                ch[3] = CH_ZERO;
                ch[4] = CH_ZERO;
                ch[5] = code(hrs[2]);
                ch[6] = code(hrs[1]);
                ch[7] = code(hrs[0]);
                ch[8] = CH_MINUS;
                ch[9] = code(dg[0]);
            end
            default: begin
            end
        endcase
        if (i_ctl.cmd == CMD_CLEAR) begin
            n_line = {5{i_blank}};
        end else begin
            for (int i = 0; i < DIGITS; i++) begin
                n_line[4*(DIGITS-1-i) +: 4] = ch[i];
            end
        end
    end

    assign beat     = (r_cnt != 3'd0) && i_tready;
    assign can_load = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_tready);
    assign load     = i_ctl.vld && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (load) begin
            r_cnt <= LINE_BYTES;
        end else if (beat) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_line <= n_line;
        end else if (beat) begin
            r_line <= {r_line[LINE_W-9:0], 8'd0};
        end
    end

    assign o_tvalid = (r_cnt != 3'd0);
    assign o_tdata  = r_line[LINE_W-1 -: 8];
    assign o_tlast  = (r_cnt == 3'd1);
    assign o_en     = !i_ctl.vld || can_load;

endmodule

`default_nettype wire

/* rtl/segment_lcd_number_formatter.sv */
// Top level of the segment LCD number formatter: APB register, pipeline, serializer.
// Depends on slnf_pkg, slnf_prep, slnf_dabble, slnf_serial and the macros header.
//
//   channel   | direction | beat
//   s_axis    | in        | one command: tuser = cmd, tdata = operands
//   m_axis    | out       | one byte of two characters, tlast on the fifth
//   apb       | in/out    | blank_byte at address 0
//
// One command becomes five output beats; the byte serializer sets the rate. It
// loads a new line when idle or as the last byte of the line before is taken.
// The first byte follows 3 front stages, 4 BCD stages and the line register load.
// Reset is synchronous and clears valid bits, the beat count and blank_byte.
// While the line register is busy and the last BCD stage holds a command, the
// whole pipeline holds and s_axis_tready drops.
`default_nettype none

module segment_lcd_number_formatter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] number, [47:32] first_value, [63:48] second_value,
    // [95:64] minutes, [96] active, [103:97] zero
    input  logic [103:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] segment_byte
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import slnf_pkg::*;

    logic             en;
    logic             blank_wr;
    logic             out_beat;
    logic [7:0]       r_blank;
    t_ctl             in_ctl;
    t_ctl             stg_ctl [DAB_STAGES+1];
    logic [BCD_W-1:0] stg_bcd [DAB_STAGES+1];
    logic [BIN_W-1:0] stg_bin [DAB_STAGES+1];

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_BLANK_IDX) ? {24'd0, r_blank} : 32'd0;
    assign blank_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BLANK_IDX);
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank <= 8'd0;
        end else if (blank_wr) begin
            r_blank <= pwdata[7:0];
        end
    end

    always_comb begin
        in_ctl        = '0;
        in_ctl.vld    = s_axis_tvalid;
        in_ctl.cmd    = t_cmd'(s_axis_tuser);
        in_ctl.active = s_axis_tdata[96];
    end

    assign s_axis_tready = en;

    slnf_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_ctl          (in_ctl),
        .i_number       (s_axis_tdata[31:0]),
        .i_first_value  (s_axis_tdata[47:32]),
        .i_second_value (s_axis_tdata[63:48]),
        .i_minutes      (s_axis_tdata[95:64]),
        .o_ctl          (stg_ctl[0]),
        .o_value        (stg_bin[0])
    );

    assign stg_bcd[0] = '0;

    for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
        slnf_dabble u_dab (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (stg_ctl[g]),
            .i_bcd   (stg_bcd[g]),
            .i_bin   (stg_bin[g]),
            .o_ctl   (stg_ctl[g+1]),
            .o_bcd   (stg_bcd[g+1]),
            .o_bin   (stg_bin[g+1])
        );
    end

    slnf_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (stg_ctl[DAB_STAGES]),
        .i_bcd    (stg_bcd[DAB_STAGES]),
        .i_blank  (r_blank),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_en     (en)
    );

`include "segment_lcd_number_formatter_macros.svh"

    `SLNF_ASSERT_SAME(a_last_has_valid, m_axis_tlast, m_axis_tvalid, "tlast without tvalid")
    `SLNF_ASSERT_NEXT(a_line_contiguous, out_beat && !m_axis_tlast, m_axis_tvalid, "line gap")
    `SLNF_ASSERT_SAME(a_stall_only_when_busy, !s_axis_tready, m_axis_tvalid, "idle stall")
    `SLNF_ASSERT_NEXT(a_blank_write, blank_wr, r_blank == $past(pwdata[7:0]), "write lost")

endmodule

`default_nettype wire

/* dv/tb_segment_lcd_number_formatter.sv */
`timescale 1ns / 100ps
// Testbench for segment_lcd_number_formatter: directed and random commands on s_axis,
// every five-byte display line predicted and checked on m_axis, blank_byte over APB.
// Depends on slnf_pkg and the RTL top level.

module tb_segment_lcd_number_formatter;
    import slnf_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int DRAIN_CYCLES     = 16;
    localparam logic [2:0] BLANK_ADDR  = 3'd0;
    localparam logic [2:0] UNUSED_ADDR = 3'd4;

    typedef struct {
        t_cmd               cmd;
        logic [31:0]        number;
        logic signed [15:0] first_value;
        logic signed [15:0] second_value;
        logic [31:0]        minutes;
        logic               active;
    } t_display_cmd;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    t_display_cmd cmd_fifo[$];
    logic [8:0]   line_bytes_q[$];  // {last, segment_byte}
    t_display_cmd cur_cmd;
    logic [7:0]   blank_value = 8'h00;
    int           queued_cnt = 0;
    int           accepted_cnt = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_gap = 0;
    int           stall_left = 0;
    logic         hold_for_drain = 1'b0;
    logic         no_idle = 1'b0;

    segment_lcd_number_formatter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [3:0] digit_char(input int unsigned d);
        return (d == 0) ? CH_ZERO : d[3:0];
    endfunction

    // least significant digit in the low nibble
    function automatic logic [39:0] decimal_chars(input int unsigned v, input int count);
        logic [39:0] s;
        int i;
        s = '0;
        for (i = 0; i < count; i++) begin
            s[4*i +: 4] = digit_char(v % 10);
            v = v / 10;
        end
        return s;
    endfunction

    function automatic logic [15:0] value_chars(input logic signed [15:0] raw);
        int v;
        logic [39:0] d;
        v = raw;
        if (v > 9999) v = 9999;
        if (v < -999) v = -999;
        if (v < 0) begin
            d = decimal_chars(-v, 3);
            return {CH_MINUS, d[11:0]};
        end
        d = decimal_chars(v, 4);
        return d[15:0];
    endfunction

    // first character in the top nibble
    function automatic logic [39:0] format_line(input t_display_cmd c, input logic [7:0] blank);
        logic [39:0] d;
        int unsigned hours;
        int unsigned tenths;
        case (c.cmd)
            CMD_NUMBER: begin
                return decimal_chars(c.number, 10);
            end
            CMD_VALUES: begin
                return {value_chars(c.first_value), CH_SPACE, CH_SPACE,
                        value_chars(c.second_value)};
            end
            CMD_TIME: begin
                hours  = c.minutes / 60;
                tenths = (c.minutes % 60) * 10 / 60;
                if (hours > 999) hours = 999;
                d = decimal_chars(hours, 6);
                return {c.active ? CH_MINUS : CH_SPACE, CH_SPACE, d[23:0], CH_MINUS,
                        digit_char(tenths)};
            end
            default: begin
                return {5{blank}};
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] random_value();
        logic [31:0] w;
        int v;
        w = $urandom;
        if ($urandom_range(0, 1) == 0) return w[15:0];
        v = int'($urandom_range(0, 11200)) - 1100;
        return v[15:0];
    endfunction

    task automatic push_cmd(input t_cmd cmd, input logic [31:0] number, input int first,
                            input int second, input logic [31:0] minutes, input logic active);
        t_display_cmd c;
        c.cmd          = cmd;
        c.number       = number;
        c.first_value  = first[15:0];
        c.second_value = second[15:0];
        c.minutes      = minutes;
        c.active       = active;
        cmd_fifo.push_back(c);
        queued_cnt++;
    endtask

    task automatic run_random_phase(input int n);
        int i;
        logic [31:0] num;
        logic [31:0] mins;
        for (i = 0; i < n; i++) begin
            num  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999) : $urandom;
            mins = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 70000) : $urandom;
            push_cmd(t_cmd'($urandom_range(0, 3)), num, int'(random_value()),
                     int'(random_value()), mins, $urandom_range(0, 1));
        end
    endtask

    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || line_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_blank_readback();
        logic [31:0] rd;
        apb_access(1'b0, BLANK_ADDR, 32'h0, rd);
        if (rd !== {24'h0, blank_value}) begin
            $error("blank_byte readback: expected %h, actual %h", {24'h0, blank_value}, rd);
            mismatch_count++;
        end
    endtask

    task automatic write_blank(input logic [7:0] value);
        logic [31:0] rd;
        apb_access(1'b1, BLANK_ADDR, {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, value}, rd);
        blank_value = value;
        check_blank_readback();
    endtask

    always @(posedge i_clk) begin : stream_driver
        logic [39:0] line;
        int k;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                line = format_line(cur_cmd, blank_value);
                for (k = 0; k < 5; k++) begin
                    line_bytes_q.push_back({k == 4, line[39-8*k -: 8]});
                end
                accepted_cnt++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (hold_for_drain && line_bytes_q.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_fifo.size() != 0) begin
                    hold_for_drain = ($urandom_range(0, 39) == 0);
                    cur_cmd = cmd_fifo.pop_front();
                    s_axis_tdata <= {7'h0, cur_cmd.active, cur_cmd.minutes,
                                     cur_cmd.second_value, cur_cmd.first_value, cur_cmd.number};
                    s_axis_tuser  <= cur_cmd.cmd;
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin : line_monitor
        logic [8:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (line_bytes_q.size() == 0) begin
                $error("segment_byte: expected none, actual %h (last %b)",
                       m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = line_bytes_q.pop_front();
                if (m_axis_tdata !== want[7:0]) begin
                    $error("segment_byte: expected %h, actual %h", want[7:0], m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want[8]) begin
                    $error("last: expected %b, actual %b", want[8], m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : main_sequence
        logic [31:0] rd;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_blank_readback();
        push_cmd(CMD_NUMBER, 32'd0, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        push_cmd(CMD_NUMBER, 32'hFFFFFFFF, $urandom, $urandom, $urandom, 1'b1);
        push_cmd(CMD_NUMBER, 32'd1234567890, $urandom, $urandom, $urandom, 1'b0);
        push_cmd(CMD_NUMBER, 32'd7, $urandom, $urandom, $urandom, 1'b0);
        push_cmd(CMD_VALUES, $urandom, 9999, -999, $urandom, 1'b0);
        push_cmd(CMD_VALUES, $urandom, 10000, -1000, $urandom, 1'b1);
        push_cmd(CMD_VALUES, $urandom, 32767, -32768, $urandom, 1'b0);
        push_cmd(CMD_VALUES, $urandom, -32768, 32767, $urandom, 1'b1);
        push_cmd(CMD_VALUES, $urandom, 0, -1, $urandom, 1'b0);
        push_cmd(CMD_VALUES, $urandom, -5, 0, $urandom, 1'b0);
        push_cmd(CMD_VALUES, $urandom, -999, 9999, $urandom, 1'b1);
        push_cmd(CMD_TIME, $urandom, $urandom, $urandom, 32'd0, 1'b0);
        push_cmd(CMD_TIME, $urandom, $urandom, $urandom, 32'd59, 1'b1);
        push_cmd(CMD_TIME, $urandom, $urandom, $urandom, 32'd60, 1'b0);
        push_cmd(CMD_TIME, $urandom, $urandom, $urandom, 32'd5, 1'b1);
        push_cmd(CMD_TIME, $urandom, $urandom, $urandom, 32'd6, 1'b0);
        push_cmd(CMD_TIME, $urandom, $urandom, $urandom, 32'd59999, 1'b1);
        push_cmd(CMD_TIME, $urandom, $urandom, $urandom, 32'd60000, 1'b0);
        push_cmd(CMD_TIME, $urandom, $urandom, $urandom, 32'hFFFFFFFF, 1'b1);
        push_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0);
        push_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b1);
        wait_drained();

        write_blank(8'hFF);
        push_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0);
        run_random_phase(RANDOM_PER_PHASE);
        wait_drained();

        // write to an unmapped register must leave blank_byte alone
        apb_access(1'b1, UNUSED_ADDR, $urandom, rd);
        check_blank_readback();

        no_idle = 1'b1;
        write_blank($urandom_range(1, 254));
        run_random_phase(RANDOM_PER_PHASE);
        wait_drained();

        no_idle = 1'b0;
        write_blank(8'h00);
        run_random_phase(RANDOM_PER_PHASE);
        wait_drained();

        write_blank($urandom_range(0, 255));
        run_random_phase(RANDOM_PER_PHASE);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/slnf_pkg.sv
rtl/slnf_prep.sv
rtl/slnf_dabble.sv
rtl/slnf_serial.sv
rtl/segment_lcd_number_formatter.sv
dv/tb_segment_lcd_number_formatter.sv
